[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/pli_pkg.sv]
// Types and constants for the positional list block
package pli_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int LEN_W        = 5;
    localparam int DEF_CAPACITY = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Request payload
    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // Result payload
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic [LEN_W-1:0]         list_length;
    } t_rsp;

    // Shift control broadcast from the controller to every cell
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_ctl;

endpackage

[rtl/core/pli_cell.sv]
// One list entry: holds, loads, or takes the left or right neighbour's value
module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_ctl                     i_ctl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_tap,
    output logic signed [DATA_W-1:0] o_entry,
    output logic signed [DATA_W-1:0] o_tap
);

    localparam int IW = ($clog2(IDX + 1) > POS_W) ? $clog2(IDX + 1) : POS_W;

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic [IW-1:0]            w_pos;
    logic [IW-1:0]            w_idx;
    logic                     w_hit;

    assign w_pos = IW'(i_ctl.pos);
    assign w_idx = IW'(IDX);
    assign w_hit = (w_idx == w_pos);

    // Next entry value
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_idx > w_pos) begin
                n_entry = i_left;
            end else if (w_hit) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            if (w_idx >= w_pos) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Read tap: pass this entry on when it sits at the requested position
    assign o_tap   = w_hit ? (i_tap | r_entry) : i_tap;
    assign o_entry = r_entry;

endmodule

[rtl/core/pli_ctrl.sv]
// Length counter and request decode for the positional list
module pli_ctrl
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_req             i_req,
    output t_ctl             o_ctl,
    output t_status          o_status,
    output logic [LEN_W-1:0] o_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [W-1:0]  w_pos;
    logic [W-1:0]  w_cnt;
    t_status       w_status;
    logic          w_ins;
    logic          w_rem;

    assign w_pos = W'(i_req.position);
    assign w_cnt = W'(r_count);

    // Status decode; empty is checked before position on remove
    always_comb begin
        w_status = ST_OK;
        if (i_req.kind == KIND_INSERT) begin
            if (w_pos > w_cnt) begin
                w_status = ST_BAD_POS;
            end else if (r_count == CW'(CAPACITY)) begin
                w_status = ST_FULL;
            end
        end else begin
            if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (w_pos >= w_cnt) begin
                w_status = ST_BAD_POS;
            end
        end
    end

    assign w_ins = i_accept && (w_status == ST_OK) && (i_req.kind == KIND_INSERT);
    assign w_rem = i_accept && (w_status == ST_OK) && (i_req.kind == KIND_REMOVE);

    // Next length
    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_ctl.ins   = w_ins;
    assign o_ctl.rem   = w_rem;
    assign o_ctl.pos   = i_req.position;
    assign o_ctl.value = i_req.value;
    assign o_status    = w_status;
    assign o_length    = LEN_W'(n_count);

endmodule

[rtl/core/positional_list_insert_remove.sv]
// Top level of the positional list: controller and a row of entry cells
//
//  channel   dir  handshake             payload
//  request   in   start / busy          i_req  (kind, position, value)
//  result    out  o_done strobe         o_rsp  (status, removed_value, list_length)
//
// One request per cycle while busy is low: the result appears with o_done in the
// cycle after the request is taken, for insert and remove alike; the row of
// cells shifts the entries from the position on at that same edge.
// busy is high during reset and in the first cycle after it.
// o_done is a one-cycle strobe and o_rsp holds until the next request is taken; the receiver cannot stall it.
module positional_list_insert_remove
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    `include "assert_macros.svh"

    logic                     r_ready;
    logic                     r_done;
    t_rsp                     r_rsp;
    t_rsp                     n_rsp;
    logic                     w_accept;
    t_ctl                     w_ctl;
    t_status                  w_status;
    logic [LEN_W-1:0]         w_length;
    logic signed [DATA_W-1:0] w_entry [CAPACITY];
    logic signed [DATA_W-1:0] w_tap   [CAPACITY+1];

    assign busy     = !r_ready || !i_rst_n;
    assign w_accept = start && !busy;

    pli_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_req),
        .o_ctl    (w_ctl),
        .o_status (w_status),
        .o_length (w_length)
    );

    // Row of cells; the read tap runs along the row beside the data
    assign w_tap[0] = '0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        pli_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_tap   (w_tap[g]),
            .o_entry (w_entry[g]),
            .o_tap   (w_tap[g+1])
        );
    end

    // Result assembly
    always_comb begin
        n_rsp.status        = w_status;
        n_rsp.removed_value = w_ctl.rem ? w_tap[CAPACITY] : '0;
        n_rsp.list_length   = w_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Checks
    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_accept, o_done)
    `ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !w_accept, !o_done)
    `ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_done && (o_rsp.status != ST_OK), o_rsp.removed_value == '0)
    `ASSERT_IMPLY(a_empty_len, i_clk, i_rst_n, o_done && (o_rsp.status == ST_EMPTY), o_rsp.list_length == '0)

endmodule
